// File: src/rbrm_pkg.sv
// Shared types, field widths, command codes and size helpers for the
// read buffer range match table. No dependencies.
package rbrm_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned IDX_W   = 2;
   localparam int unsigned SIZE_W  = 2;
   localparam int unsigned FAULT_W = 4;
   localparam int unsigned LEN_W   = 6;

   // Payload widths on the stream ports (tdata padded to whole bytes).
   localparam int unsigned REQ_FIELDS_W = ADDR_W + IDX_W + SIZE_W + FAULT_W;
   localparam int unsigned REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = IDX_W + SIZE_W + FAULT_W;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INVAL    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_INVAL_ALL = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_4    = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_16   = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_32   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ADDR_W-1:0]  addr;
      logic [IDX_W-1:0]   entry_index;
      logic [SIZE_W-1:0]  size_code;
      logic [FAULT_W-1:0] fault_code;
   } cmd_type;

   typedef struct packed {
      logic               match;
      logic [SIZE_W-1:0]  size;
      logic [FAULT_W-1:0] fault;
   } cell_stat_type;

   typedef struct packed {
      logic               hit;
      logic [IDX_W-1:0]   hit_index;
      logic [SIZE_W-1:0]  hit_size;
      logic [FAULT_W-1:0] hit_fault;
   } rsp_type;

   // Range length in bytes for a size code; the invalid code has none.
   function automatic logic [LEN_W-1:0] size_len(input logic [SIZE_W-1:0] size);
      logic [LEN_W-1:0] len;
      unique case (size)
         SIZE_NONE: len = 6'd0;
         SIZE_4:    len = 6'd4;
         SIZE_16:   len = 6'd16;
         SIZE_32:   len = 6'd32;
         default:   len = 6'd0;
      endcase
      return len;
   endfunction

   // Mask that aligns an address down to the length; the invalid code
   // clears the whole address.
   function automatic logic [ADDR_W-1:0] align_mask(input logic [SIZE_W-1:0] size);
      logic [ADDR_W-1:0] mask;
      unique case (size)
         SIZE_NONE: mask = '0;
         SIZE_4:    mask = ~ADDR_W'(32'd3);
         SIZE_16:   mask = ~ADDR_W'(32'd15);
         SIZE_32:   mask = ~ADDR_W'(32'd31);
         default:   mask = '0;
      endcase
      return mask;
   endfunction

endpackage

// File: src/rbrm_cell.sv
// One table entry: its stored range and fault, the search compare, the
// overlap test against a load, and its own update. Uses rbrm_pkg.
module rbrm_cell
   import rbrm_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic          commit,
   output cell_stat_type stat
);

   // Only entries reachable by the index field can be written or cleared singly.
   localparam bit ADDRESSABLE = (INDEX < (1 << IDX_W));

   logic [ADDR_W-1:0]  addr_ff,  addr_in;
   logic [SIZE_W-1:0]  size_ff,  size_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;

   logic               valid;
   logic [ADDR_W-1:0]  old_end;
   logic [ADDR_W-1:0]  new_start;
   logic [ADDR_W-1:0]  new_end;
   logic [ADDR_W-1:0]  ov_hi;
   logic [ADDR_W-1:0]  ov_lo;
   logic               overlap;
   logic               selected;

   assign valid   = (size_ff != SIZE_NONE);
   assign old_end = addr_ff + ADDR_W'(size_len(size_ff));

   assign new_start = cmd.addr & align_mask(cmd.size_code);
   assign new_end   = new_start + ADDR_W'(size_len(cmd.size_code));
   assign ov_hi     = (new_start > addr_ff) ? new_start : addr_ff;
   assign ov_lo     = (new_end < old_end) ? new_end : old_end;
   assign overlap   = valid && (ov_hi < ov_lo);

   assign selected = ADDRESSABLE && (cmd.entry_index == IDX_W'(INDEX));

   assign stat.match = valid && (cmd.addr >= addr_ff) && (cmd.addr < old_end);
   assign stat.size  = size_ff;
   assign stat.fault = fault_ff;

   always_comb begin
      addr_in  = addr_ff;
      size_in  = size_ff;
      fault_in = fault_ff;
      if (commit) begin
         unique case (cmd.cmd)
            CMD_SEARCH: begin
            end
            CMD_LOAD: begin
               // Overlap clears first; a write to this entry then wins.
               if (overlap) begin
                  size_in = SIZE_NONE;
               end
               if (selected) begin
                  addr_in  = new_start;
                  size_in  = cmd.size_code;
                  fault_in = cmd.fault_code;
               end
            end
            CMD_INVAL: begin
               if (selected) begin
                  size_in = SIZE_NONE;
               end
            end
            CMD_INVAL_ALL: begin
               size_in = SIZE_NONE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_NONE;
         fault_ff <= '0;
      end else begin
         size_ff  <= size_in;
         fault_ff <= fault_in;
      end
   end

   // The address is only ever read while the entry is valid.
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

// File: src/read_buffer_range_match_table.sv
// Top level of the read buffer range match table: stream ports, input and
// result registers, the row of entry cells and the priority pick. Uses
// rbrm_pkg and rbrm_cell.

// Every command transfer yields exactly one result transfer, in order.
// A new command can be taken in every clock cycle unless the result side is
// stalled by rsp_tready, so the sustained rate is one item per cycle; each
// command passes the input register and then the result register. That rate
// is set by the table itself: all ENTRIES entries are compared against the
// registered command in parallel, the lowest-numbered match is picked, and a
// load or invalidate updates the entries in the same cycle the result is
// captured, so the next command always sees the updated table.
// Search returns the first valid entry whose range contains the address;
// load aligns the address to its size, clears every valid entry that
// overlaps the new range and then writes the chosen entry; invalidate one
// clears a single entry and invalidate all clears the whole table. Results
// of commands other than search are all zero. Entries at index four and
// above exist only when ENTRIES grows beyond the index field's reach; they
// are never written, so they stay invalid and never hit.
module read_buffer_range_match_table
   import rbrm_pkg::*;
#(
   parameter int unsigned ENTRIES = 4
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] addr, [33:32] entry_index, [35:34] size_code, [39:36] fault_code
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [CMD_W-1:0]      req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] hit_index, [3:2] hit_size, [7:4] hit_fault
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] hit
   output logic                  rsp_tuser
);

   logic          in_valid_ff, in_valid_in;
   cmd_type       in_cmd_ff, in_cmd_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic          req_fire;
   logic          rsp_fire;
   logic          advance;

   cell_stat_type stat [ENTRIES];
   rsp_type       pick;

   // The held command moves on when the result register is free or is
   // being emptied in this cycle; the input register then takes a new one.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;

   always_comb begin
      in_cmd_in = in_cmd_ff;
      if (req_fire) begin
         in_cmd_in.cmd         = req_tuser;
         in_cmd_in.addr        = req_tdata[ADDR_W-1:0];
         in_cmd_in.entry_index = req_tdata[ADDR_W+IDX_W-1:ADDR_W];
         in_cmd_in.size_code   = req_tdata[ADDR_W+IDX_W+SIZE_W-1:ADDR_W+IDX_W];
         in_cmd_in.fault_code  = req_tdata[REQ_FIELDS_W-1:ADDR_W+IDX_W+SIZE_W];
      end
   end

   always_comb begin
      priority if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Each cell holds one entry and updates itself when the command commits.
   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      rbrm_cell #(
         .INDEX (k)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (in_cmd_ff),
         .commit (advance),
         .stat   (stat[k])
      );
   end

   // Lowest-numbered matching entry wins: scan from the top down so that
   // lower entries overwrite higher ones.
   always_comb begin
      pick = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (stat[k].match) begin
            pick.hit       = 1'b1;
            pick.hit_index = IDX_W'(k);
            pick.hit_size  = stat[k].size;
            pick.hit_fault = stat[k].fault;
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      if (advance) begin
         out_in = (in_cmd_ff.cmd == CMD_SEARCH) ? pick : '0;
      end
   end

   always_comb begin
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff <= in_cmd_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.hit;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.hit_fault, out_ff.hit_size, out_ff.hit_index});

endmodule

// File: src/rbrm_checker.sv
// Port-level checks for the read buffer range match table, and the bind
// that attaches them to the top level. Uses rbrm_pkg.
module rbrm_checker
   import rbrm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result is offered straight after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A miss, or any command other than search, reports all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with non-zero fields");

   // A hit always comes from a valid entry, so its size is never invalid.
   a_hit_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[IDX_W+SIZE_W-1:IDX_W] != SIZE_NONE)
      else $error("hit on an invalid entry");

endmodule

bind read_buffer_range_match_table rbrm_checker u_rbrm_checker (.*);

// File: verif/rbrm_tb_pkg.sv
// Scoreboard for the read buffer range match table testbench: a shadow copy
// of the tag table that predicts each response, and the response checker.
// Depends on rbrm_pkg.
package rbrm_tb_pkg;
   import rbrm_pkg::*;

   localparam int unsigned TABLE_DEPTH = 1 << IDX_W;

   class lookup_scoreboard;
      logic [ADDR_W-1:0]  shadow_start [TABLE_DEPTH];
      logic [SIZE_W-1:0]  shadow_size  [TABLE_DEPTH];
      logic [FAULT_W-1:0] shadow_fault [TABLE_DEPTH];
      rsp_type            expected_lookups [$];
      int unsigned        errors;
      int unsigned        checked;
      int unsigned        searches;
      int unsigned        hits;
      int unsigned        loads;
      int unsigned        clears;

      function new();
         int k;
         for (k = 0; k < TABLE_DEPTH; k++) begin
            shadow_start[k] = '0;
            shadow_size[k]  = SIZE_NONE;
            shadow_fault[k] = '0;
         end
      endfunction

      function int unsigned pending();
         return expected_lookups.size();
      endfunction

      // Byte length covered by an entry of the given size.
      function logic [ADDR_W-1:0] range_bytes(logic [SIZE_W-1:0] sz);
         logic [ADDR_W-1:0] len;
         case (sz)
            SIZE_4:  len = 32'd4;
            SIZE_16: len = 32'd16;
            SIZE_32: len = 32'd32;
            default: len = 32'd0;
         endcase
         return len;
      endfunction

      // Updates the shadow table and returns the response the command causes.
      function rsp_type predict_lookup(cmd_type item);
         rsp_type           rsp;
         logic [ADDR_W-1:0] len, start, stop, os, oe, hi, lo;
         int                k;
         rsp = '0;
         case (item.cmd)
            CMD_SEARCH: begin
               searches++;
               for (k = 0; k < TABLE_DEPTH; k++) begin
                  if (!rsp.hit && shadow_size[k] != SIZE_NONE) begin
                     stop = shadow_start[k] + range_bytes(shadow_size[k]);
                     if (item.addr >= shadow_start[k] && item.addr < stop) begin
                        rsp.hit       = 1'b1;
                        rsp.hit_index = IDX_W'(k);
                        rsp.hit_size  = shadow_size[k];
                        rsp.hit_fault = shadow_fault[k];
                     end
                  end
               end
               if (rsp.hit)
                  hits++;
            end
            CMD_LOAD: begin
               loads++;
               len   = range_bytes(item.size_code);
               // A zero length gives an all-zero mask and an empty range.
               start = item.addr & ~(len - 32'd1);
               stop  = start + len;
               for (k = 0; k < TABLE_DEPTH; k++) begin
                  if (shadow_size[k] != SIZE_NONE) begin
                     os = shadow_start[k];
                     oe = os + range_bytes(shadow_size[k]);
                     hi = (start > os) ? start : os;
                     lo = (stop < oe) ? stop : oe;
                     if (hi < lo)
                        shadow_size[k] = SIZE_NONE;
                  end
               end
               shadow_start[item.entry_index] = start;
               shadow_size[item.entry_index]  = item.size_code;
               shadow_fault[item.entry_index] = item.fault_code;
            end
            CMD_INVAL: begin
               clears++;
               shadow_size[item.entry_index] = SIZE_NONE;
            end
            default: begin
               clears++;
               for (k = 0; k < TABLE_DEPTH; k++)
                  shadow_size[k] = SIZE_NONE;
            end
         endcase
         return rsp;
      endfunction

      function void note_command(cmd_type item);
         expected_lookups.push_back(predict_lookup(item));
      endfunction

      function void check_response(rsp_type seen);
         rsp_type want;
         if (expected_lookups.size() == 0) begin
            $error("response transfer with no command outstanding (hit %0d)", seen.hit);
            errors++;
            return;
         end
         want = expected_lookups.pop_front();
         checked++;
         if (seen.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, seen.hit);
            errors++;
         end
         if (seen.hit_index !== want.hit_index) begin
            $error("hit_index: expected %0d, got %0d", want.hit_index, seen.hit_index);
            errors++;
         end
         if (seen.hit_size !== want.hit_size) begin
            $error("hit_size: expected %0d, got %0d", want.hit_size, seen.hit_size);
            errors++;
         end
         if (seen.hit_fault !== want.hit_fault) begin
            $error("hit_fault: expected %0d, got %0d", want.hit_fault, seen.hit_fault);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: verif/tb_top.sv
// Top of the read buffer range match table testbench: clock, reset, the
// command sender, the response receiver and the stimulus sequence.
// Depends on rbrm_pkg, rbrm_tb_pkg and read_buffer_range_match_table.
module tb_top;
   import rbrm_pkg::*;
   import rbrm_tb_pkg::*;

   // Idle allowance after the last response, kept well above the time a
   // command takes through the input and result registers.
   localparam int unsigned DRAIN_CYCLES = 12;
   // Slowest correct run: every transfer delayed by the longest sender gap
   // and the longest receiver stall, plus the deliberate hold-off.
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned MAX_GAP      = 17;
   localparam int unsigned PHASES       = 6;
   localparam int unsigned PHASE_ITEMS  = 230;
   localparam int unsigned SQUEEZE_ITEMS = 40;
   localparam int unsigned HOLD_OFF     = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   lookup_scoreboard board;
   int unsigned      cycle_count     = 0;
   int unsigned      sent_count      = 0;
   int unsigned      rsp_hold_cycles = 0;
   // While set, neither side idles; otherwise each draws a gap per transfer.
   bit               steady_flow     = 1'b0;

   read_buffer_range_match_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned pick_gap();
      if (steady_flow)
         return 0;
      // Roughly a third of the transfers go back to back even in a busy phase.
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic cmd_type make_command(input logic [CMD_W-1:0] cmd,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [IDX_W-1:0] index,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [FAULT_W-1:0] fault);
      cmd_type item;
      item.cmd         = cmd;
      item.addr        = addr;
      item.entry_index = index;
      item.size_code   = size;
      item.fault_code  = fault;
      return item;
   endfunction

   // Random command aimed at a 128-byte window, so that loads overlap one
   // another and searches land on live entries. A small share is noise with
   // any command code and an address anywhere.
   function automatic cmd_type random_command(input logic [ADDR_W-1:0] window);
      cmd_type     item;
      int unsigned pick;
      pick             = $urandom_range(0, 99);
      item.addr        = window + ADDR_W'($urandom_range(0, 127));
      item.entry_index = IDX_W'($urandom);
      item.fault_code  = FAULT_W'($urandom);
      if ($urandom_range(0, 9) == 0)
         item.size_code = SIZE_NONE;
      else
         item.size_code = SIZE_W'($urandom_range(1, 3));
      if (pick < 45) begin
         item.cmd = CMD_SEARCH;
      end else if (pick < 80) begin
         item.cmd = CMD_LOAD;
      end else if (pick < 90) begin
         item.cmd = CMD_INVAL;
      end else if (pick < 93) begin
         item.cmd = CMD_INVAL_ALL;
      end else begin
         item.cmd  = CMD_W'($urandom);
         item.addr = ADDR_W'($urandom);
      end
      return item;
   endfunction

   // Offers one command after a gap of idle cycles and returns once the
   // transfer has taken place. Valid is touched once per falling edge, so a
   // back-to-back command simply keeps it high.
   task automatic send_command(input cmd_type item, input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= item.cmd;
      req_tdata  <= {item.fault_code, item.size_code, item.entry_index, item.addr};
      do @(posedge clock); while (!req_tready);
      board.note_command(item);
      sent_count++;
   endtask

   task automatic wait_for_drain();
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // Response side: stalls for a drawn number of cycles (or a requested long
   // hold-off), then takes one response transfer and checks it.
   task automatic receive_responses();
      int unsigned stall;
      rsp_type     seen;
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen.hit       = rsp_tuser;
         seen.hit_index = rsp_tdata[1:0];
         seen.hit_size  = rsp_tdata[3:2];
         seen.hit_fault = rsp_tdata[7:4];
         board.check_response(seen);
      end
   endtask

   initial begin
      cmd_type           directed [$];
      logic [ADDR_W-1:0] window;
      int unsigned       phase;
      int unsigned       n;

      board = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      fork
         receive_responses();
      join_none

      // Directed part. A search of the empty table, an exact four-byte
      // boundary, a range that wraps past the top of the address space and
      // so never matches, loads that knock out overlapping entries (also when
      // the new entry sits wholly inside an old one), a load with the invalid
      // size that writes address zero, and both kinds of invalidation.
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_0000, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'h0000_1003, 2'd0, SIZE_4,    4'h0));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_1003, 2'd3, SIZE_32,   4'hF));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_1004, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_0FFF, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'hFFFF_FFFF, 2'd1, SIZE_32,   4'hF));
      directed.push_back(make_command(CMD_SEARCH, 32'hFFFF_FFF0, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_SEARCH, 32'hFFFF_FFFF, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'h0000_101C, 2'd2, SIZE_16,   4'h5));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_101F, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'h0000_1000, 2'd3, SIZE_32,   4'h9));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_1010, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'h0000_1009, 2'd0, SIZE_4,    4'h3));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_100B, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_1000, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'hDEAD_BEEF, 2'd2, SIZE_NONE, 4'hA));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_0000, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'hFFFF_FFFC, 2'd3, SIZE_4,    4'hC));
      directed.push_back(make_command(CMD_SEARCH, 32'hFFFF_FFFD, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_INVAL,  32'h0000_0000, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_1008, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_LOAD,   32'h0000_0000, 2'd1, SIZE_32,   4'hF));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_001F, 2'd0, SIZE_NONE, 4'h0));
      directed.push_back(make_command(CMD_INVAL_ALL, 32'hFFFF_FFFF, 2'd3, SIZE_32, 4'hF));
      directed.push_back(make_command(CMD_SEARCH, 32'h0000_0000, 2'd0, SIZE_NONE, 4'h0));
      foreach (directed[i])
         send_command(directed[i], pick_gap());

      // Random part: each phase works in a fresh window, some of them at the
      // bottom and top of the address space, and every third phase runs with
      // no idling on either side.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       window = 32'h0000_0000;
            4:       window = 32'hFFFF_FF80;
            default: window = ADDR_W'($urandom);
         endcase
         steady_flow = (phase % 3 == 1);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_command(random_command(window), pick_gap());

         if (phase == 2) begin
            // The receiver holds off for a long stretch while commands keep
            // coming back to back, so the block fills up and stops taking
            // transfers; afterwards the sender goes quiet and waits for every
            // response.
            rsp_hold_cycles = HOLD_OFF;
            for (n = 0; n < SQUEEZE_ITEMS; n++)
               send_command(random_command(window), 0);
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
      end
      steady_flow = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands and checked %0d responses in %0d cycles.",
               sent_count, board.checked, cycle_count);
      $display("That took in %0d searches (%0d hits), %0d loads and %0d invalidations.",
               board.searches, board.hits, board.loads, board.clears);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
